FILE: rtl/scanline_unfilter_rgb_alpha_macros.svh
// Assertion macros shared by the scanline unfilter RTL.
`ifndef SCANLINE_UNFILTER_RGB_ALPHA_MACROS_SVH
`define SCANLINE_UNFILTER_RGB_ALPHA_MACROS_SVH
`ifndef SYNTHESIS
// Checked while out of reset.
`define SURA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked at every edge, reset included.
`define SURA_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SURA_ASSERT(lbl, prop, msg)
`define SURA_ASSERT_ANY(lbl, prop, msg)
`endif
`endif

FILE: rtl/sura_pkg.sv
// Types, constants and mode decode for the scanline unfilter.
package sura_pkg;

  localparam int unsigned MAX_WIDTH = 1024;
  localparam int unsigned COL_W     = $clog2(MAX_WIDTH);
  localparam int unsigned WIDTH_W   = 11;
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned LANES     = 3;
  localparam int unsigned COLOUR_W  = LANES * PIX_W;

  localparam int unsigned S_TDATA_W = 32;
  localparam int unsigned S_TUSER_W = 2;
  localparam int unsigned M_TDATA_W = 40;
  localparam int unsigned M_TUSER_W = 1;

  localparam logic [WIDTH_W-1:0] WIDTH_CAP = WIDTH_W'(MAX_WIDTH);

  localparam logic [PIX_W-1:0] MODE_NONE  = 8'd0;
  localparam logic [PIX_W-1:0] MODE_SUB   = 8'd1;
  localparam logic [PIX_W-1:0] MODE_UP    = 8'd2;
  localparam logic [PIX_W-1:0] MODE_AVG   = 8'd3;
  localparam logic [PIX_W-1:0] MODE_PAETH = 8'd4;

  localparam logic [PIX_W-1:0] ALPHA_OPAQUE = 8'd255;

  typedef enum logic [2:0] {
    FILT_NONE,
    FILT_SUB,
    FILT_UP,
    FILT_AVG,
    FILT_PAETH,
    FILT_UNKNOWN
  } filt_e;

  typedef struct packed {
    filt_e filt;
    logic  col_zero;
  } pred_ctrl_t;

  function automatic filt_e decode_mode(logic [PIX_W-1:0] mode);
    filt_e f;
    f = FILT_UNKNOWN;
    if (mode == MODE_NONE)  f = FILT_NONE;
    if (mode == MODE_SUB)   f = FILT_SUB;
    if (mode == MODE_UP)    f = FILT_UP;
    if (mode == MODE_AVG)   f = FILT_AVG;
    if (mode == MODE_PAETH) f = FILT_PAETH;
    return f;
  endfunction

endpackage

FILE: rtl/sura_channel.sv
// One byte lane of the row predictor: none, sub, up, average and Paeth.
module sura_channel (
  input  sura_pkg::pred_ctrl_t        ctrl_i,
  input  logic [sura_pkg::PIX_W-1:0]  left_i,
  input  logic [sura_pkg::PIX_W-1:0]  up_i,
  input  logic [sura_pkg::PIX_W-1:0]  upleft_i,
  input  logic [sura_pkg::PIX_W-1:0]  resid_i,
  output logic [sura_pkg::PIX_W-1:0]  pix_o
);
  import sura_pkg::*;

  logic [PIX_W-1:0] left;
  logic [PIX_W-1:0] pred;
  logic [PIX_W-1:0] paeth_pred;
  logic [PIX_W:0]   sum_lu;
  logic signed [PIX_W+1:0] d_pa;
  logic signed [PIX_W+1:0] d_pb;
  logic signed [PIX_W+1:0] d_pc;
  logic [PIX_W+1:0] pa;
  logic [PIX_W+1:0] pb;
  logic [PIX_W+1:0] pc;

  // Left restarts at zero on column 0, except in Paeth and unknown rows
  assign left = (ctrl_i.col_zero && ctrl_i.filt != FILT_PAETH
                 && ctrl_i.filt != FILT_UNKNOWN) ? '0 : left_i;

  assign sum_lu = {1'b0, left} + {1'b0, up_i};

  // p - a = b - c, p - b = a - c, p - c = a + b - 2c
  assign d_pa = $signed({2'b00, up_i}) - $signed({2'b00, upleft_i});
  assign d_pb = $signed({2'b00, left}) - $signed({2'b00, upleft_i});
  assign d_pc = $signed({2'b00, left}) + $signed({2'b00, up_i})
              - $signed({1'b0, upleft_i, 1'b0});

  assign pa = d_pa[PIX_W+1] ? 10'(-d_pa) : 10'(d_pa);
  assign pb = d_pb[PIX_W+1] ? 10'(-d_pb) : 10'(d_pb);
  assign pc = d_pc[PIX_W+1] ? 10'(-d_pc) : 10'(d_pc);

  always_comb begin
    priority if (pa <= pb && pa <= pc) begin
      paeth_pred = left;
    end else if (pb <= pc) begin
      paeth_pred = up_i;
    end else begin
      paeth_pred = upleft_i;
    end
  end

  always_comb begin
    unique case (ctrl_i.filt)
      FILT_NONE:  pred = '0;
      FILT_SUB:   pred = left;
      FILT_UP:    pred = up_i;
      FILT_AVG:   pred = sum_lu[PIX_W:1];
      FILT_PAETH: pred = ctrl_i.col_zero ? up_i : paeth_pred;
      default:    pred = '0;
    endcase
  end

  // Unknown rows repeat the left value and drop the residual
  assign pix_o = (ctrl_i.filt == FILT_UNKNOWN) ? left : PIX_W'(pred + resid_i);

endmodule

FILE: rtl/sura_line_store.sv
// Previous-row stores for the colour and alpha planes, with write bypass.
module sura_line_store (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_colour_i,
  input  logic                          wr_alpha_i,
  input  logic [sura_pkg::COL_W-1:0]    wr_addr_i,
  input  logic [sura_pkg::COLOUR_W-1:0] wr_colour_data_i,
  input  logic [sura_pkg::PIX_W-1:0]    wr_alpha_data_i,
  input  logic [sura_pkg::COL_W-1:0]    rd_addr_i,
  output logic [sura_pkg::COLOUR_W-1:0] up_colour_o,
  output logic [sura_pkg::PIX_W-1:0]    up_alpha_o
);
  import sura_pkg::*;

  `include "scanline_unfilter_rgb_alpha_macros.svh"

  logic [COLOUR_W-1:0] colour_mem [MAX_WIDTH];
  logic [PIX_W-1:0]    alpha_mem  [MAX_WIDTH];

  logic [COLOUR_W-1:0] rd_colour_q;
  logic [PIX_W-1:0]    rd_alpha_q;
  logic [COLOUR_W-1:0] byp_colour_data_q;
  logic [PIX_W-1:0]    byp_alpha_data_q;
  logic                byp_colour_q;
  logic                byp_alpha_q;
  logic                same_addr;

  assign same_addr = (wr_addr_i == rd_addr_i);

  always_ff @(posedge clk_i) begin
    if (wr_colour_i) begin
      colour_mem[wr_addr_i] <= wr_colour_data_i;
    end
    rd_colour_q <= colour_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (wr_alpha_i) begin
      alpha_mem[wr_addr_i] <= wr_alpha_data_i;
    end
    rd_alpha_q <= alpha_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    byp_colour_data_q <= wr_colour_data_i;
    byp_alpha_data_q  <= wr_alpha_data_i;
  end

  // Read and write on the same entry in the same cycle: the written data is bypassed to the read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_colour_q <= 1'b0;
      byp_alpha_q  <= 1'b0;
    end else begin
      byp_colour_q <= wr_colour_i && same_addr;
      byp_alpha_q  <= wr_alpha_i && same_addr;
    end
  end

  assign up_colour_o = byp_colour_q ? byp_colour_data_q : rd_colour_q;
  assign up_alpha_o  = byp_alpha_q ? byp_alpha_data_q : rd_alpha_q;

  `SURA_ASSERT(a_byp_colour_src, byp_colour_q |-> $past(wr_colour_i), "colour bypass without write")
  `SURA_ASSERT(a_byp_alpha_src, byp_alpha_q |-> $past(wr_alpha_i), "alpha bypass without write")

endmodule

FILE: rtl/scanline_unfilter_rgb_alpha.sv
// Top level of the scanline unfilter: item registers, row state and lanes.
//
// Rebuilds pixels from PNG-style filtered residuals, one item per pixel.
// Slave stream: tdata = filter_mode, resid_red, resid_green, resid_blue;
// tuser = command (0 colour, 1 alpha), first_of_plane. Master stream:
// tdata = red, green, blue, alpha, residual_used; tuser = plane.
// cfg_we_i/cfg_wdata_i set the row width; write it only while the block is
// idle. Widths above the line store depth are clamped on write.
// Every item gives exactly one result. An accepted item sits in the input
// register, is rebuilt by the predictor lanes once the output register is
// free and lands there to drive tvalid. Without a stall, one item per cycle
// is sustained; the limit is the left-neighbour path through one lane.
// The previous-row entry for the next item is fetched in advance from
// the line store, so the store read never sits in the pixel path.
// Reset clears row state, the width to 1 and both stream valid flags; line
// stores are not cleared and hold data only once a row has written them.
// When the receiver stalls, the result holds and one more item is taken
// into the input register; after that tready drops.
module scanline_unfilter_rgb_alpha (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sura_pkg::WIDTH_W-1:0]   cfg_wdata_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [7:0] filter_mode, [15:8] resid_red, [23:16] resid_green, [31:24] resid_blue
  input  logic [sura_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // [0] command, [1] first_of_plane
  input  logic [sura_pkg::S_TUSER_W-1:0] s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [7:0] red_out, [15:8] green_out, [23:16] blue_out, [31:24] alpha_out,
  // [32] residual_used, rest zero
  output logic [sura_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // [0] plane
  output logic [sura_pkg::M_TUSER_W-1:0] m_axis_tuser
);
  import sura_pkg::*;

  `include "scanline_unfilter_rgb_alpha_macros.svh"

  logic [WIDTH_W-1:0]   width_q;
  logic                 in_valid_q;
  logic [S_TDATA_W-1:0] in_data_q;
  logic [S_TUSER_W-1:0] in_user_q;
  logic                 out_valid_q;
  logic [M_TDATA_W-1:0] out_data_q;
  logic [M_TUSER_W-1:0] out_user_q;

  logic [COL_W-1:0]          col_q;
  logic [COL_W-1:0]          col_d;
  logic                      past_q;
  logic                      past_d;
  logic [LANES-1:0][PIX_W-1:0] left_colour_q;
  logic [LANES-1:0][PIX_W-1:0] upleft_colour_q;
  logic [PIX_W-1:0]          left_alpha_q;
  logic [PIX_W-1:0]          upleft_alpha_q;
  logic [PIX_W-1:0]          held_alpha_q;
  logic [PIX_W-1:0]          held_alpha_d;

  logic                 accept;
  logic                 advance;
  logic                 proc;
  logic                 item_cmd;
  logic                 item_first;
  logic [COL_W-1:0]     item_col;
  logic                 item_past;
  filt_e                filt;
  logic                 known;
  pred_ctrl_t           pctrl;
  logic [COL_W:0]       col_inc;
  logic                 wrap;
  logic [WIDTH_W-1:0]   cfg_width;

  logic [COLOUR_W-1:0]         store_colour;
  logic [PIX_W-1:0]            store_alpha;
  logic [LANES-1:0][PIX_W-1:0] up_colour;
  logic [LANES-1:0][PIX_W-1:0] ul_colour;
  logic [PIX_W-1:0]            up_alpha;
  logic [PIX_W-1:0]            ul_alpha;
  logic [LANES-1:0][PIX_W-1:0] lane_left;
  logic [LANES-1:0][PIX_W-1:0] lane_up;
  logic [LANES-1:0][PIX_W-1:0] lane_ul;
  logic [LANES-1:0][PIX_W-1:0] lane_resid;
  logic [LANES-1:0][PIX_W-1:0] lane_pix;
  logic [M_TDATA_W-1:0]        out_data_d;

  // Stream handshakes
  assign advance       = !out_valid_q || m_axis_tready;
  assign proc          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign cfg_width = (cfg_wdata_i > WIDTH_CAP) ? WIDTH_CAP : cfg_wdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WIDTH_W'(1);
    end else if (cfg_we_i) begin
      width_q <= cfg_width;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (proc) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_data_q <= s_axis_tdata;
      in_user_q <= s_axis_tuser;
    end
  end

  // Current item decode
  assign item_cmd   = in_user_q[0];
  assign item_first = in_user_q[1];
  assign item_col   = item_first ? '0 : col_q;
  assign item_past  = !item_first && past_q;
  assign filt       = decode_mode(in_data_q[PIX_W-1:0]);
  assign known      = (filt != FILT_UNKNOWN);

  assign pctrl.filt     = filt;
  assign pctrl.col_zero = (item_col == '0);

  // Column advance; an item at or past the last column wraps the row
  assign col_inc = {1'b0, item_col} + 1'b1;
  assign wrap    = (WIDTH_W'(col_inc) >= width_q);

  always_comb begin
    col_d  = col_q;
    past_d = past_q;
    if (proc) begin
      col_d  = wrap ? '0 : col_inc[COL_W-1:0];
      past_d = wrap || item_past;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      past_q <= 1'b0;
    end else begin
      col_q  <= col_d;
      past_q <= past_d;
    end
  end

  sura_line_store u_line_store (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .wr_colour_i      (proc && !item_cmd),
    .wr_alpha_i       (proc && item_cmd),
    .wr_addr_i        (item_col),
    .wr_colour_data_i (lane_pix),
    .wr_alpha_data_i  (lane_pix[LANES-1]),
    .rd_addr_i        (col_d),
    .up_colour_o      (store_colour),
    .up_alpha_o       (store_alpha)
  );

  // First row of a plane sees zero above
  assign up_colour = item_past ? store_colour : '0;
  assign ul_colour = item_past ? upleft_colour_q : '0;
  assign up_alpha  = item_past ? store_alpha : '0;
  assign ul_alpha  = item_past ? upleft_alpha_q : '0;

  // Lane 2 (red) also carries alpha samples
  always_comb begin
    lane_left  = left_colour_q;
    lane_up    = up_colour;
    lane_ul    = ul_colour;
    lane_resid = in_data_q[S_TDATA_W-1:PIX_W];
    if (item_cmd) begin
      lane_left[LANES-1] = left_alpha_q;
      lane_up[LANES-1]   = up_alpha;
      lane_ul[LANES-1]   = ul_alpha;
    end
    lane_resid[LANES-1] = in_data_q[2*PIX_W-1:PIX_W];
    lane_resid[0]       = in_data_q[4*PIX_W-1:3*PIX_W];
    lane_resid[1]       = in_data_q[3*PIX_W-1:2*PIX_W];
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    sura_channel u_channel (
      .ctrl_i   (pctrl),
      .left_i   (lane_left[g]),
      .up_i     (lane_up[g]),
      .upleft_i (lane_ul[g]),
      .resid_i  (lane_resid[g]),
      .pix_o    (lane_pix[g])
    );
  end

  assign held_alpha_d = (proc && !item_cmd && known) ? ALPHA_OPAQUE : held_alpha_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_colour_q   <= '0;
      upleft_colour_q <= '0;
      left_alpha_q    <= '0;
      upleft_alpha_q  <= '0;
      held_alpha_q    <= '0;
    end else begin
      held_alpha_q <= held_alpha_d;
      if (proc && !item_cmd) begin
        left_colour_q   <= lane_pix;
        upleft_colour_q <= up_colour;
      end
      if (proc && item_cmd) begin
        left_alpha_q   <= lane_pix[LANES-1];
        upleft_alpha_q <= up_alpha;
      end
    end
  end

  always_comb begin
    if (item_cmd) begin
      out_data_d = M_TDATA_W'({known, lane_pix[LANES-1], {COLOUR_W{1'b0}}});
    end else begin
      out_data_d = M_TDATA_W'({known, held_alpha_d,
                               lane_pix[0], lane_pix[1], lane_pix[2]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      out_data_q <= out_data_d;
      out_user_q <= M_TUSER_W'(item_cmd);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  `SURA_ASSERT(a_stall_holds, (out_valid_q && !m_axis_tready) |=> (out_valid_q && $stable(out_data_q)), "result moved under stall")
  `SURA_ASSERT(a_proc_gives_result, proc |=> out_valid_q, "processed item gave no result")
  `SURA_ASSERT(a_plane_follows_cmd, proc |=> (out_user_q[0] == $past(item_cmd)), "plane mismatch")
  `SURA_ASSERT(a_unknown_keeps_alpha, (proc && !known) |=> $stable(held_alpha_q), "held alpha moved")

endmodule
